### rtl/core/ddt_pkg.sv
// ----------------------------------------------------------------------------
// ddt_pkg
// Shared types, widths and codes of the deadline timer table.
// ----------------------------------------------------------------------------
package ddt_pkg;

  // Default sizing of the table
  localparam int NUM_TIMERS_DEF = 16;
  localparam int TICK_WIDTH_DEF = 32;

  // Fixed field widths of the request and response beats
  localparam int REQ_W   = 2;
  localparam int ID_W    = 4;
  localparam int TICKS_W = 32;
  localparam int SLEEP_W = 16;

  // At most this many expiries are reported by one process request
  localparam int MAX_FIRE = 16;

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam int CFG_IW = APB_AW - 2;

  localparam logic [CFG_IW-1:0]  CFG_MAX_SLEEP = '0;
  localparam logic [SLEEP_W-1:0] SLEEP_RST     = 16'd62;

  typedef enum logic [REQ_W-1:0] {
    REQ_ARM   = 2'd0,
    REQ_STOP  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_PROC  = 2'd3
  } req_e;

  typedef struct packed {
    logic               fired;
    logic [ID_W-1:0]    expired_id;
    logic               is_pending;
    logic [SLEEP_W-1:0] next_delay;
    logic               last;
  } rsp_t;

  // Result beat handed from the engine to the output register
  typedef struct packed {
    logic valid;
    rsp_t rsp;
  } beat_t;

endpackage

### rtl/core/ddt_req_if.sv
// ----------------------------------------------------------------------------
// ddt_req_if
// Request channel: valid/ready handshake with one request per beat.
// ----------------------------------------------------------------------------
interface ddt_req_if import ddt_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [ID_W-1:0]    timer_id;
  logic [TICKS_W-1:0] delay_ticks;
  logic [TICKS_W-1:0] now_ticks;

  modport source (
    output valid, req_type, timer_id, delay_ticks, now_ticks,
    input  ready
  );

  modport sink (
    input  valid, req_type, timer_id, delay_ticks, now_ticks,
    output ready
  );

endinterface

### rtl/core/ddt_rsp_if.sv
// ----------------------------------------------------------------------------
// ddt_rsp_if
// Response channel: valid/ready handshake with one result per beat.
// ----------------------------------------------------------------------------
interface ddt_rsp_if import ddt_pkg::*; ();

  logic               valid;
  logic               ready;
  logic               fired;
  logic [ID_W-1:0]    expired_id;
  logic               is_pending;
  logic [SLEEP_W-1:0] next_delay;
  logic               last;

  modport source (
    output valid, fired, expired_id, is_pending, next_delay, last,
    input  ready
  );

  modport sink (
    input  valid, fired, expired_id, is_pending, next_delay, last,
    output ready
  );

endinterface

### rtl/core/ddt_apb_regs.sv
// ----------------------------------------------------------------------------
// ddt_apb_regs
// APB register file holding the sleep cap of the timer table.
// ----------------------------------------------------------------------------
module ddt_apb_regs import ddt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready,
  output logic [SLEEP_W-1:0] max_sleep_o
);

  logic [SLEEP_W-1:0] sleep_q, sleep_d;
  logic [CFG_IW-1:0]  idx;
  logic               wr;

  assign pready      = 1'b1;
  assign idx         = paddr[APB_AW-1:2];
  assign wr          = psel & penable & pwrite;
  assign max_sleep_o = sleep_q;

  always_comb begin
    sleep_d = sleep_q;
    prdata  = '0;
    unique case (idx)
      CFG_MAX_SLEEP: begin
        prdata = APB_DW'(sleep_q);
        if (wr) begin
          sleep_d = pwdata[SLEEP_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sleep_q <= SLEEP_RST;
    end else begin
      sleep_q <= sleep_d;
    end
  end

endmodule

### rtl/core/ddt_rsp_reg.sv
// ----------------------------------------------------------------------------
// ddt_rsp_reg
// Output register between the engine and the response channel.
// ----------------------------------------------------------------------------
module ddt_rsp_reg import ddt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  beat_t     beat_i,
  output logic      space_o,
  ddt_rsp_if.source rsp_o
);

  logic vld_q;
  rsp_t rsp_q;

  // Free when empty or when the held beat leaves this cycle
  assign space_o = !vld_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (beat_i.valid) begin
      vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_i.valid) begin
      rsp_q <= beat_i.rsp;
    end
  end

  assign rsp_o.valid      = vld_q;
  assign rsp_o.fired      = rsp_q.fired;
  assign rsp_o.expired_id = rsp_q.expired_id;
  assign rsp_o.is_pending = rsp_q.is_pending;
  assign rsp_o.next_delay = rsp_q.next_delay;
  assign rsp_o.last       = rsp_q.last;

endmodule

### rtl/core/ddt_engine.sv
// ----------------------------------------------------------------------------
// ddt_engine
// Request sequencer over the order list and deadline memories.
// ----------------------------------------------------------------------------
module ddt_engine import ddt_pkg::*; #(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF,
  parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  ddt_req_if.sink            req_i,
  input  logic [SLEEP_W-1:0] max_sleep_i,
  input  logic               space_i,
  output beat_t              beat_o
);

  localparam int IW  = $clog2(NUM_TIMERS);
  localparam int CW  = $clog2(NUM_TIMERS + 1);
  localparam int NFW = $clog2(MAX_FIRE + 1);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_DROP   = 9'b000000010,
    ST_SHIFT  = 9'b000000100,
    ST_ARMFIN = 9'b000001000,
    ST_REPLY  = 9'b000010000,
    ST_PORD   = 9'b000100000,
    ST_PDL    = 9'b001000000,
    ST_PEV    = 9'b010000000,
    ST_PFIN   = 9'b100000000
  } state_e;

  state_e                state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [NUM_TIMERS-1:0] armed_q, armed_d;
  logic                  rd_vld_q, rd_vld_d;

  logic [CW-1:0]         p_q, p_d;
  logic [CW-1:0]         w_q, w_d;
  logic [IW-1:0]         ra_q, ra_d;
  logic [IW-1:0]         id_q, id_d;
  logic [IW-1:0]         cur_q, cur_d;
  logic                  ok_q, ok_d;
  req_e                  req_q, req_d;
  logic [TICK_WIDTH-1:0] now_q, now_d;
  logic [TICK_WIDTH-1:0] delay_q, delay_d;
  logic [TICK_WIDTH-1:0] min_q, min_d;
  logic [NFW-1:0]        nf_q, nf_d;

  // Order list: position 0 holds the newest armed slot
  logic [IW-1:0]         ord_mem [NUM_TIMERS];
  logic [IW-1:0]         ord_rd_q;
  logic                  ord_we, ord_re;
  logic [IW-1:0]         ord_wa, ord_ra, ord_wd;

  // Deadline per slot
  logic [TICK_WIDTH-1:0] dl_mem [NUM_TIMERS];
  logic [TICK_WIDTH-1:0] dl_rd_q;
  logic                  dl_we, dl_re;

  logic                  in_ok;
  logic [IW-1:0]         in_id;
  req_e                  in_req;
  logic [TICK_WIDTH-1:0] diff;
  logic                  diff_neg;
  logic                  fire;
  logic [CW-1:0]         p_inc;

  assign req_i.ready = (state_q == ST_IDLE);

  assign in_ok    = (32'(req_i.timer_id) < 32'(NUM_TIMERS));
  assign in_id    = IW'(req_i.timer_id);
  assign in_req   = req_e'(req_i.req_type);
  assign diff     = dl_rd_q - now_q;
  assign diff_neg = diff[TICK_WIDTH-1];
  assign fire     = diff_neg && (nf_q != NFW'(MAX_FIRE));
  assign p_inc    = p_q + CW'(1);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    armed_d  = armed_q;
    rd_vld_d = rd_vld_q;
    p_d      = p_q;
    w_d      = w_q;
    ra_d     = ra_q;
    id_d     = id_q;
    cur_d    = cur_q;
    ok_d     = ok_q;
    req_d    = req_q;
    now_d    = now_q;
    delay_d  = delay_q;
    min_d    = min_q;
    nf_d     = nf_q;
    ord_we   = 1'b0;
    ord_wa   = '0;
    ord_wd   = '0;
    ord_re   = 1'b0;
    ord_ra   = '0;
    dl_we    = 1'b0;
    dl_re    = 1'b0;
    beat_o   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          req_d    = in_req;
          id_d     = in_id;
          ok_d     = in_ok;
          now_d    = TICK_WIDTH'(req_i.now_ticks);
          delay_d  = TICK_WIDTH'(req_i.delay_ticks);
          p_d      = '0;
          w_d      = '0;
          rd_vld_d = 1'b0;
          nf_d     = '0;
          min_d    = TICK_WIDTH'(max_sleep_i);
          unique case (in_req)
            REQ_ARM: begin
              if (!in_ok) begin
                state_d = ST_REPLY;
              end else if (armed_q[in_id]) begin
                state_d = ST_DROP;
              end else begin
                p_d     = cnt_q;
                state_d = ST_SHIFT;
              end
            end
            REQ_STOP: begin
              if (in_ok && armed_q[in_id]) begin
                state_d = ST_DROP;
              end else begin
                state_d = ST_REPLY;
              end
            end
            REQ_QUERY: begin
              state_d = ST_REPLY;
            end
            REQ_PROC: begin
              state_d = ST_PORD;
            end
            default: begin
              state_d = ST_REPLY;
            end
          endcase
        end
      end

      // Compact the list, leaving out the addressed slot
      ST_DROP: begin
        if (rd_vld_q && (ord_rd_q != id_q)) begin
          ord_we = 1'b1;
          ord_wa = IW'(w_q);
          ord_wd = ord_rd_q;
          w_d    = w_q + CW'(1);
        end
        if (p_q != cnt_q) begin
          ord_re   = 1'b1;
          ord_ra   = IW'(p_q);
          p_d      = p_inc;
          rd_vld_d = 1'b1;
        end else begin
          rd_vld_d = 1'b0;
        end
        if ((p_q == cnt_q) && !rd_vld_q) begin
          armed_d[id_q] = 1'b0;
          cnt_d         = w_q;
          if (req_q == REQ_ARM) begin
            p_d     = w_q;
            state_d = ST_SHIFT;
          end else begin
            state_d = ST_REPLY;
          end
        end
      end

      // Move every entry one place down, last entry first
      ST_SHIFT: begin
        if (rd_vld_q) begin
          ord_we = 1'b1;
          ord_wa = ra_q + IW'(1);
          ord_wd = ord_rd_q;
        end
        if (p_q != '0) begin
          ord_re   = 1'b1;
          ord_ra   = IW'(p_q - CW'(1));
          ra_d     = IW'(p_q - CW'(1));
          p_d      = p_q - CW'(1);
          rd_vld_d = 1'b1;
        end else begin
          rd_vld_d = 1'b0;
        end
        if ((p_q == '0) && !rd_vld_q) begin
          state_d = ST_ARMFIN;
        end
      end

      ST_ARMFIN: begin
        ord_we        = 1'b1;
        ord_wa        = '0;
        ord_wd        = id_q;
        dl_we         = 1'b1;
        armed_d[id_q] = 1'b1;
        cnt_d         = cnt_q + CW'(1);
        state_d       = ST_REPLY;
      end

      ST_REPLY: begin
        if (space_i) begin
          beat_o.valid          = 1'b1;
          beat_o.rsp.is_pending = (req_q == REQ_QUERY) && ok_q && armed_q[id_q];
          beat_o.rsp.last       = 1'b1;
          state_d               = ST_IDLE;
        end
      end

      ST_PORD: begin
        if (p_q == cnt_q) begin
          state_d = ST_PFIN;
        end else begin
          ord_re  = 1'b1;
          ord_ra  = IW'(p_q);
          state_d = ST_PDL;
        end
      end

      ST_PDL: begin
        dl_re   = 1'b1;
        cur_d   = ord_rd_q;
        state_d = ST_PEV;
      end

      // Fire or keep one entry; hold while a fired beat has no room
      ST_PEV: begin
        if (!fire || space_i) begin
          if (fire) begin
            beat_o.valid          = 1'b1;
            beat_o.rsp.fired      = 1'b1;
            beat_o.rsp.expired_id = ID_W'(cur_q);
            armed_d[cur_q]        = 1'b0;
            nf_d                  = nf_q + NFW'(1);
          end else begin
            ord_we = 1'b1;
            ord_wa = IW'(w_q);
            ord_wd = cur_q;
            w_d    = w_q + CW'(1);
            if (!diff_neg && (diff < min_q)) begin
              min_d = diff;
            end
          end
          p_d = p_inc;
          if (p_inc != cnt_q) begin
            ord_re  = 1'b1;
            ord_ra  = IW'(p_inc);
            state_d = ST_PDL;
          end else begin
            state_d = ST_PFIN;
          end
        end
      end

      ST_PFIN: begin
        if (space_i) begin
          beat_o.valid          = 1'b1;
          beat_o.rsp.next_delay = (min_q == '0) ? SLEEP_W'(1) : SLEEP_W'(min_q);
          beat_o.rsp.last       = 1'b1;
          cnt_d                 = w_q;
          state_d               = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      armed_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      armed_q  <= armed_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    w_q     <= w_d;
    ra_q    <= ra_d;
    id_q    <= id_d;
    cur_q   <= cur_d;
    ok_q    <= ok_d;
    req_q   <= req_d;
    now_q   <= now_d;
    delay_q <= delay_d;
    min_q   <= min_d;
    nf_q    <= nf_d;
  end

  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      ord_mem[ord_wa] <= ord_wd;
    end
    if (ord_re) begin
      ord_rd_q <= ord_mem[ord_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dl_we) begin
      dl_mem[id_q] <= now_q + delay_q;
    end
    if (dl_re) begin
      dl_rd_q <= dl_mem[ord_rd_q];
    end
  end

endmodule

### rtl/core/deadline_timer_table.sv
// ----------------------------------------------------------------------------
// deadline_timer_table
// Table of software timers with arm, stop, query and expiry processing.
// ----------------------------------------------------------------------------
//
//   port      | kind        | dir | beat
//   ----------+-------------+-----+------------------------------------------
//   req_i     | valid/ready | in  | req_type, timer_id, delay_ticks, now_ticks
//   rsp_o     | valid/ready | out | fired, expired_id, is_pending,
//             |             |     | next_delay, last
//   apb       | APB write/  | in  | max_sleep_ticks at byte address 0
//             | read        |     |
//
// One request is worked on at a time; req_i is ready only while idle.
// Work per request: query only replies; stop of an armed slot
// compacts the order list; arm compacts it if the slot is already
// armed, then shifts the order list; process reads the order and
// deadline memories for each armed timer.
// Reset clears the armed flags and the list count; memory contents
// are not reset and are only read below the count. A stalled rsp_o
// holds the engine in place until the output register frees up.
// ----------------------------------------------------------------------------
module deadline_timer_table import ddt_pkg::*; #(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF,
  parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ddt_req_if.sink           req_i,
  ddt_rsp_if.source         rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // Sleep cap from the register file
  logic [SLEEP_W-1:0] max_sleep;

  // Engine to output register
  beat_t              beat;
  logic               space;

  ddt_apb_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_sleep_o (max_sleep)
  );

  // Walk the order list (newest first) and the deadline memory
  ddt_engine #(
    .NUM_TIMERS (NUM_TIMERS),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .max_sleep_i (max_sleep),
    .space_i     (space),
    .beat_o      (beat)
  );

  // Hold each result beat until the sink takes it
  ddt_rsp_reg u_rsp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .beat_i  (beat),
    .space_o (space),
    .rsp_o   (rsp_o)
  );

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the deadline timer table: directed and random
// request traffic, predicted results and per-field checking of every beat.
// ----------------------------------------------------------------------------
module testbench;
  import ddt_pkg::*;

  // Receiver stall patterns
  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_MOSTLY,
    RX_PATTERN
  } rx_mode_e;

  // Cycles with no beat anywhere before the run is declared hung
  localparam int STUCK_LIMIT = 4000;
  // Quiet cycles after the last result, before the verdict
  localparam int TAIL_CYCLES = 48;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  ddt_req_if req_if ();
  ddt_rsp_if rsp_if ();

  deadline_timer_table u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Timer table shadow: armed flags, deadlines, insertion ages (0 = newest)
  // and the sleep cap register.
  // --------------------------------------------------------------------------
  logic               armed_q    [NUM_TIMERS_DEF];
  logic [TICKS_W-1:0] deadline_q [NUM_TIMERS_DEF];
  int                 age_q      [NUM_TIMERS_DEF];
  logic [SLEEP_W-1:0] sleep_cap;

  // Results still owed by the block, oldest first
  rsp_t expected_q[$];
  int   mismatches;

  // Sender and receiver pacing
  int       burst_left;
  int       gap_max;
  rx_mode_e rx_mode;
  int       rx_phase;
  int       hold_ask;
  int       hold_left;

  // Running tick count used by well-formed traffic
  logic [TICKS_W-1:0] tick_now;

  // Disarm a slot and close the gap it leaves in the age order
  function automatic void drop_timer(int s);
    if (!armed_q[s]) return;
    for (int i = 0; i < NUM_TIMERS_DEF; i++) begin
      if (armed_q[i] && age_q[i] > age_q[s]) age_q[i]--;
    end
    armed_q[s] = 1'b0;
  endfunction

  // Update the shadow table for one accepted request and queue its results
  function automatic void predict_timers(req_e kind, logic [ID_W-1:0] id,
                                         logic [TICKS_W-1:0] dly,
                                         logic [TICKS_W-1:0] now_tk);
    rsp_t               r;
    int                 best;
    logic [TICKS_W-1:0] diff;
    logic [TICKS_W-1:0] mind;
    r = '0;
    case (kind)
      REQ_ARM: begin
        drop_timer(int'(id));
        for (int i = 0; i < NUM_TIMERS_DEF; i++) begin
          if (armed_q[i]) age_q[i]++;
        end
        deadline_q[id] = now_tk + dly;
        age_q[id]      = 0;
        armed_q[id]    = 1'b1;
      end
      REQ_STOP:  drop_timer(int'(id));
      REQ_QUERY: r.is_pending = armed_q[id];
      default: begin
        // Fire expired slots newest first, one beat each
        for (int n = 0; n < MAX_FIRE; n++) begin
          best = -1;
          for (int i = 0; i < NUM_TIMERS_DEF; i++) begin
            diff = deadline_q[i] - now_tk;
            if (armed_q[i] && diff[TICKS_W-1] && (best < 0 || age_q[i] < age_q[best]))
              best = i;
          end
          if (best < 0) break;
          drop_timer(best);
          r            = '0;
          r.fired      = 1'b1;
          r.expired_id = ID_W'(best);
          expected_q.push_back(r);
        end
        // Sleep until the nearest pending deadline, capped, at least one tick
        mind = TICKS_W'(sleep_cap);
        for (int i = 0; i < NUM_TIMERS_DEF; i++) begin
          diff = deadline_q[i] - now_tk;
          if (armed_q[i] && !diff[TICKS_W-1] && diff < mind) mind = diff;
        end
        if (mind == '0) mind = 1;
        r            = '0;
        r.next_delay = mind[SLEEP_W-1:0];
      end
    endcase
    r.last = 1'b1;
    expected_q.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: bursts of back-to-back beats split by random gaps
  // --------------------------------------------------------------------------
  task automatic send_req(req_e kind, logic [ID_W-1:0] id,
                          logic [TICKS_W-1:0] dly, logic [TICKS_W-1:0] now_tk);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      gap        = (gap_max > 0) ? $urandom_range(1, gap_max) : 0;
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_if.valid       <= 1'b1;
    req_if.req_type    <= kind;
    req_if.timer_id    <= id;
    req_if.delay_ticks <= dly;
    req_if.now_ticks   <= now_tk;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    predict_timers(kind, id, dly, now_tk);
  endtask

  // Drop valid and hold off until every owed result has come back
  task automatic wait_idle();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Write the sleep cap over APB, then read it back
  task automatic write_sleep_cap(logic [SLEEP_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {CFG_MAX_SLEEP, 2'b00};
    pwdata  <= APB_DW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sleep_cap = value;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[SLEEP_W-1:0] !== value) begin
      $display("%0t: max_sleep_ticks readback expected %0d actual %0d",
               $time, value, prdata[SLEEP_W-1:0]);
      mismatches++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result receiver: stall pattern per mode, plus a long hold-off on request
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_ask > 0) begin
      hold_left = hold_ask;
      hold_ask  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS:  rsp_if.ready <= 1'b1;
        RX_COIN:    rsp_if.ready <= 1'($urandom_range(0, 1));
        RX_MOSTLY:  rsp_if.ready <= ($urandom_range(0, 3) != 0);
        default:    rsp_if.ready <= ((rx_phase % 7) < 4);
      endcase
      rx_phase++;
    end
  end

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each result beat with the oldest owed result
  always @(posedge clk_i) begin : check_results
    rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat expected none actual fired=%0b id=%0d",
                 $time, rsp_if.fired, rsp_if.expired_id);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        check_field("fired",      16'(want.fired),      16'(rsp_if.fired));
        check_field("expired_id", 16'(want.expired_id), 16'(rsp_if.expired_id));
        check_field("is_pending", 16'(want.is_pending), 16'(rsp_if.is_pending));
        check_field("next_delay", want.next_delay,      rsp_if.next_delay);
        check_field("last",       16'(want.last),       16'(rsp_if.last));
      end
    end
  end

  // Watchdog: end the run when no beat moves anywhere for too long
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (psel && penable))
        stuck = 0;
      else
        stuck++;
    end
    $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Zero difference, sign-bit deadlines, wrap of the tick count, stop of an
  // idle slot and re-arm of an armed slot
  task automatic test_directed();
    rx_mode = RX_MOSTLY;
    gap_max = 3;
    send_req(REQ_QUERY, 4'd0,  32'd0,          32'd0);
    send_req(REQ_ARM,   4'd0,  32'd0,          32'd100);
    send_req(REQ_QUERY, 4'd0,  32'd0,          32'd0);
    send_req(REQ_PROC,  4'd0,  32'd0,          32'd100);
    send_req(REQ_PROC,  4'd0,  32'd0,          32'd101);
    send_req(REQ_ARM,   4'd15, 32'hFFFF_FFFF,  32'hFFFF_FFFF);
    send_req(REQ_PROC,  4'd15, 32'hFFFF_FFFF,  32'hFFFF_FFFF);
    send_req(REQ_ARM,   4'd3,  32'h7FFF_FFFF,  32'd0);
    send_req(REQ_ARM,   4'd4,  32'h8000_0000,  32'd0);
    send_req(REQ_PROC,  4'd0,  32'd0,          32'd0);
    send_req(REQ_STOP,  4'd3,  32'd0,          32'd0);
    send_req(REQ_QUERY, 4'd3,  32'd0,          32'd0);
    send_req(REQ_STOP,  4'd3,  32'd0,          32'd0);
    send_req(REQ_ARM,   4'd5,  32'd10,         32'd0);
    send_req(REQ_ARM,   4'd6,  32'd20,         32'd0);
    send_req(REQ_ARM,   4'd5,  32'd5,          32'd0);
    send_req(REQ_QUERY, 4'd5,  32'd0,          32'd0);
    send_req(REQ_PROC,  4'd9,  32'd0,          32'd30);
    wait_idle();
  endtask

  // Sleep cap at zero, at the top and at one, with and without pending timers
  task automatic test_sleep_cap();
    write_sleep_cap(16'd0);
    send_req(REQ_ARM,  4'd1, 32'd1000, 32'd0);
    send_req(REQ_PROC, 4'd0, 32'd0,    32'd0);
    wait_idle();
    write_sleep_cap(16'hFFFF);
    send_req(REQ_PROC, 4'd0, 32'd0,    32'd0);
    wait_idle();
    write_sleep_cap(16'd1);
    send_req(REQ_PROC, 4'd0, 32'd0,    32'd500);
    send_req(REQ_STOP, 4'd1, 32'd0,    32'd0);
    send_req(REQ_PROC, 4'd0, 32'd0,    32'd0);
    wait_idle();
  endtask

  // Arm every slot in shuffled order, then expire them all in one request
  task automatic test_full_table();
    int order [NUM_TIMERS_DEF];
    int j;
    int t;
    for (int i = 0; i < NUM_TIMERS_DEF; i++) order[i] = i;
    for (int i = NUM_TIMERS_DEF - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    write_sleep_cap(16'd62);
    rx_mode  = RX_COIN;
    gap_max  = 0;
    tick_now = $urandom();
    for (int i = 0; i < NUM_TIMERS_DEF; i++)
      send_req(REQ_ARM, ID_W'(order[i]), $urandom_range(1, 50), tick_now);
    send_req(REQ_PROC, 4'd0, 32'd0, tick_now + 100);
    wait_idle();
  endtask

  // Hold the result side off while requests keep coming so the input stalls
  task automatic test_backpressure();
    hold_ask = 300;
    gap_max  = 0;
    rx_mode  = RX_ALWAYS;
    for (int i = 0; i < 8; i++)
      send_req(REQ_ARM, ID_W'($urandom_range(0, 15)), $urandom_range(0, 40), tick_now);
    send_req(REQ_PROC,  4'd0, 32'd0, tick_now + 20);
    send_req(REQ_QUERY, ID_W'($urandom_range(0, 15)), 32'd0, tick_now);
    send_req(REQ_STOP,  ID_W'($urandom_range(0, 15)), 32'd0, tick_now);
    wait_idle();
  endtask

  // Mostly well-formed traffic on an advancing tick, with some raw noise
  task automatic run_traffic(int count);
    int                 pick;
    logic [ID_W-1:0]    id;
    logic [TICKS_W-1:0] dly;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      id   = ID_W'($urandom_range(0, 15));
      if (pick < 40) begin
        case ($urandom_range(0, 9))
          0:       dly = $urandom();
          1, 2:    dly = $urandom_range(0, 65535);
          default: dly = $urandom_range(0, 300);
        endcase
        send_req(REQ_ARM, id, dly, tick_now);
      end else if (pick < 52) begin
        send_req(REQ_STOP, id, $urandom(), tick_now);
      end else if (pick < 64) begin
        send_req(REQ_QUERY, id, $urandom(), tick_now);
      end else if (pick < 92) begin
        tick_now = tick_now + $urandom_range(0, 160);
        send_req(REQ_PROC, id, $urandom(), tick_now);
      end else begin
        send_req(req_e'(REQ_W'($urandom_range(0, 3))), id, $urandom(), $urandom());
      end
    end
  endtask

  // Four phases, each with its own cap and pacing; three set a new starting tick
  task automatic test_random_traffic();
    write_sleep_cap(16'($urandom_range(30, 200)));
    rx_mode  = RX_MOSTLY;
    gap_max  = 4;
    tick_now = $urandom();
    run_traffic(60);
    wait_idle();

    // Start just below the wrap of the tick count
    write_sleep_cap(16'd1);
    rx_mode  = RX_COIN;
    gap_max  = 8;
    tick_now = 32'hFFFF_FF00;
    run_traffic(60);
    wait_idle();

    // No idling on either side
    write_sleep_cap(16'hFFFF);
    rx_mode  = RX_ALWAYS;
    gap_max  = 0;
    run_traffic(60);
    wait_idle();

    write_sleep_cap(16'($urandom_range(2, 400)));
    rx_mode  = RX_PATTERN;
    gap_max  = 3;
    tick_now = $urandom();
    run_traffic(60);
    wait_idle();
  endtask

  initial begin
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    req_if.valid       = 1'b0;
    req_if.req_type    = REQ_ARM;
    req_if.timer_id    = '0;
    req_if.delay_ticks = '0;
    req_if.now_ticks   = '0;
    rsp_if.ready       = 1'b0;
    mismatches         = 0;
    burst_left         = 0;
    gap_max            = 0;
    rx_mode            = RX_ALWAYS;
    rx_phase           = 0;
    hold_ask           = 0;
    hold_left          = 0;
    tick_now           = '0;
    sleep_cap          = 16'd62;
    for (int i = 0; i < NUM_TIMERS_DEF; i++) begin
      armed_q[i]    = 1'b0;
      deadline_q[i] = '0;
      age_q[i]      = 0;
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_sleep_cap();
    test_full_table();
    test_backpressure();
    test_random_traffic();

    // Let any stray beat show up before the verdict
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
